### src/itst_pkg.sv
// Shared types and constants for the inter-thread stride trainer.
package itst_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int STRIDE_SLOTS_DEF  = 3;
  localparam logic [7:0] THRESHOLD_RESET = 8'd2;
  localparam logic [7:0] COUNT_MAX       = 8'hFF;

  typedef struct packed {
    logic [31:0] program_counter;
    logic [31:0] access_address;
    logic [15:0] thread_id;
  } in_t;

  typedef struct packed {
    logic signed [31:0] predicted_stride;
    logic               table_hit;
    logic               is_trained;
  } out_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] prev_addr;
    logic [15:0] last_thread;
    logic [31:0] pred_stride;
    logic        trained_flag;
  } entry_t;

  typedef struct packed {
    logic [31:0] stride;
    logic [7:0]  count;
  } slot_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_HIT,
    S_DIV,
    S_VOTE,
    S_BEST,
    S_ALLOC,
    S_RESP
  } state_t;

endpackage

### src/itst_div.sv
// Signed 32 by 17 bit restoring divider, one quotient bit per cycle, truncating.
module itst_div
  import itst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [16:0] divisor,
  output div_ctl_t           status,
  output logic [31:0]        quotient
);

  logic [31:0] a_r;
  logic [15:0] rem_r;
  logic [15:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        neg_r;

  logic [31:0] sd_u;
  logic [16:0] dt_u;
  logic [31:0] a_abs;
  logic [16:0] b_abs;
  logic [16:0] sh;
  logic        ge;

  always_comb begin
    sd_u  = dividend;
    dt_u  = divisor;
    a_abs = sd_u[31] ? (~sd_u + 32'd1) : sd_u;
    b_abs = dt_u[16] ? (~dt_u + 17'd1) : dt_u;
    sh    = {rem_r, a_r[31]};
    ge    = sh >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_abs;
      b_r   <= b_abs[15:0];
      rem_r <= '0;
      neg_r <= sd_u[31] ^ dt_u[16];
    end else if (busy_r) begin
      rem_r <= ge ? 16'(sh - {1'b0, b_r}) : sh[15:0];
      a_r   <= {a_r[30:0], ge};
    end
  end

  assign status.start = start;
  assign status.done  = done_r;
  assign quotient     = neg_r ? (~a_r + 32'd1) : a_r;

endmodule

### src/inter_thread_stride_trainer.sv
// Inter-thread stride trainer: program-counter table, slot voting and response path.
// One access is handled at a time. The table is searched one entry at a time: each
// entry is read through the entry memory's read port, then compared, up to the hit
// or the last filled entry. A miss then allocates and responds; a hit from the same
// thread updates the entry and responds; a hit from a new thread runs the serial
// divider that produces one quotient bit per cycle, then votes, picks the best slot
// and responds, waiting for the output register if needed. Entries are allocated
// in order and then replaced oldest first; no clearing pass is needed after reset.
// A new access is accepted while the previous result is still waiting in the
// output register.
module inter_thread_stride_trainer
  import itst_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int STRIDE_SLOTS  = STRIDE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W = $clog2(STRIDE_SLOTS);

  state_t state_r, state_nxt;

  logic [7:0]        thr_r;
  in_t               in_r;
  logic [IDX_W-1:0]  scan_r;
  logic [IDX_W-1:0]  alloc_r;
  logic [FILL_W-1:0] fill_r;
  out_t              resp_r;
  out_t              out_r;
  logic              out_valid_r;

  entry_t ent_mem [TABLE_ENTRIES];
  entry_t ent_rd_r;
  slot_t [STRIDE_SLOTS-1:0] slot_mem [TABLE_ENTRIES];
  slot_t [STRIDE_SLOTS-1:0] slot_rd_r;
  slot_t [STRIDE_SLOTS-1:0] row_r;

  logic ent_re, slot_re, ent_we, slot_we, div_start, out_load;
  logic [IDX_W-1:0] waddr;
  entry_t ent_wdata;
  slot_t [STRIDE_SLOTS-1:0] slot_wdata;

  logic is_hit, last_scan, same_thread;
  logic signed [31:0] sd;
  logic signed [16:0] dt;
  div_ctl_t div_st;
  logic [31:0] quot;
  slot_t [STRIDE_SLOTS-1:0] row_nxt;
  logic [SLOT_W-1:0] best;
  logic train_flag;

  assign is_hit      = ent_rd_r.pc == in_r.program_counter;
  assign last_scan   = (FILL_W'(scan_r) + FILL_W'(1)) == fill_r;
  assign same_thread = ent_rd_r.last_thread == in_r.thread_id;
  assign sd          = in_r.access_address - ent_rd_r.prev_addr;
  assign dt          = {1'b0, in_r.thread_id} - {1'b0, ent_rd_r.last_thread};
  assign out_load    = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (fill_r == '0) ? S_ALLOC : S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP: begin
        if (is_hit)         state_nxt = S_HIT;
        else if (last_scan) state_nxt = S_ALLOC;
        else                state_nxt = S_READ;
      end
      S_HIT:   state_nxt = same_thread ? S_RESP : S_DIV;
      S_DIV:   if (div_st.done) state_nxt = S_VOTE;
      S_VOTE:  state_nxt = S_BEST;
      S_BEST:  state_nxt = S_RESP;
      S_ALLOC: state_nxt = S_RESP;
      S_RESP:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    ent_re    = 1'b0;
    slot_re   = 1'b0;
    ent_we    = 1'b0;
    slot_we   = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_READ:  ent_re = 1'b1;
      S_HIT: begin
        slot_re   = 1'b1;
        ent_we    = same_thread;
        div_start = !same_thread;
      end
      S_BEST: begin
        ent_we  = 1'b1;
        slot_we = 1'b1;
      end
      S_ALLOC: begin
        ent_we  = 1'b1;
        slot_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Slot vote: match, else lowest empty, else lowest minimum
  always_comb begin
    logic m_found, e_found;
    logic [SLOT_W-1:0] m_idx, e_idx, mi;
    m_found = 1'b0;
    e_found = 1'b0;
    m_idx   = '0;
    e_idx   = '0;
    mi      = '0;
    row_nxt = slot_rd_r;
    for (int k = 0; k < STRIDE_SLOTS; k++) begin
      if (!m_found && slot_rd_r[k].count != '0 && slot_rd_r[k].stride == quot) begin
        m_found = 1'b1;
        m_idx   = SLOT_W'(k);
      end
      if (!e_found && slot_rd_r[k].count == '0) begin
        e_found = 1'b1;
        e_idx   = SLOT_W'(k);
      end
    end
    for (int k = 1; k < STRIDE_SLOTS; k++) begin
      if (slot_rd_r[k].count < slot_rd_r[mi].count) mi = SLOT_W'(k);
    end
    if (m_found) begin
      if (slot_rd_r[m_idx].count != COUNT_MAX)
        row_nxt[m_idx].count = slot_rd_r[m_idx].count + 8'd1;
    end else if (e_found) begin
      row_nxt[e_idx] = '{stride: quot, count: 8'd1};
    end else begin
      row_nxt[mi] = '{stride: quot, count: 8'd1};
    end
  end

  // Best slot: lowest index with the highest count
  always_comb begin
    best = '0;
    for (int k = 1; k < STRIDE_SLOTS; k++) begin
      if (row_r[k].count > row_r[best].count) best = SLOT_W'(k);
    end
    train_flag = row_r[best].count > thr_r;
  end

  always_comb begin
    waddr      = (state_r == S_ALLOC) ? alloc_r : scan_r;
    slot_wdata = (state_r == S_ALLOC) ? '0 : row_r;
    ent_wdata.pc          = in_r.program_counter;
    ent_wdata.prev_addr   = in_r.access_address;
    ent_wdata.last_thread = in_r.thread_id;
    case (state_r)
      S_BEST: begin
        ent_wdata.pred_stride  = row_r[best].stride;
        ent_wdata.trained_flag = train_flag;
      end
      S_HIT: begin
        ent_wdata.pred_stride  = ent_rd_r.pred_stride;
        ent_wdata.trained_flag = ent_rd_r.trained_flag;
      end
      default: begin
        ent_wdata.pred_stride  = '0;
        ent_wdata.trained_flag = 1'b0;
      end
    endcase
  end

  itst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sd),
    .divisor  (dt),
    .status   (div_st),
    .quotient (quot)
  );

  // Memories
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[waddr] <= ent_wdata;
    if (ent_re) ent_rd_r <= ent_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[waddr] <= slot_wdata;
    if (slot_re) slot_rd_r <= slot_mem[scan_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THRESHOLD_RESET;
      alloc_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) thr_r <= cfg_data;
      if (state_r == S_ALLOC) begin
        alloc_r <= (alloc_r == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : alloc_r + IDX_W'(1);
        if (fill_r != FILL_W'(TABLE_ENTRIES)) fill_r <= fill_r + FILL_W'(1);
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r   <= in_data;
      scan_r <= '0;
    end
    if (state_r == S_CMP && !is_hit && !last_scan) scan_r <= scan_r + IDX_W'(1);
    if (state_r == S_VOTE) row_r <= row_nxt;
    case (state_r)
      S_HIT:   resp_r <= '{predicted_stride: ent_rd_r.pred_stride, table_hit: 1'b1,
                           is_trained: ent_rd_r.trained_flag};
      S_BEST:  resp_r <= '{predicted_stride: row_r[best].stride, table_hit: 1'b1,
                           is_trained: train_flag};
      S_ALLOC: resp_r <= '0;
      default: ;
    endcase
    if (out_load) out_r <= resp_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted access not processed");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.table_hit) |-> (out_r.predicted_stride == '0 && !out_r.is_trained))
    else $error("miss result carries a stride");

endmodule
